[src/albm_pkg.sv]
package albm_pkg;

    localparam int WINDOW_LEN_DEF  = 60;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int DC_W      = 12;
    localparam int NF_W      = 11;
    localparam int BAR_W     = 8;
    localparam int TIMEOUT_W = 16;
    localparam int TIME_W    = 32;
    localparam int SMOOTH_W  = 12;
    localparam int AVG_MIN_W = 12;
    localparam int QCNT_W    = 3;

    localparam int FILT_SHIFT = 3;
    localparam int AVG_SHIFT  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_DC_OFFSET       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOISE_FLOOR     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAR_TOP         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_TIMEOUT_MS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_FALL_FRAMES = 3'd4;

    localparam logic [DC_W-1:0]      DC_OFFSET_RESET   = 12'd0;
    localparam logic [NF_W-1:0]      NOISE_FLOOR_RESET = 11'd30;
    localparam logic [BAR_W-1:0]     BAR_TOP_RESET     = 8'd171;
    localparam logic [TIMEOUT_W-1:0] PEAK_TIMEOUT_RESET = 16'd1000;
    localparam logic [BAR_W-1:0]     PEAK_FALL_RESET   = 8'd4;

    localparam int LEVEL_RESET   = 10;
    localparam int MAX_AVG_RESET = 2048;

    typedef struct packed {
        logic wr;
        logic scan;
    } win_req_t;

    typedef struct packed {
        logic busy;
    } win_stat_t;

endpackage

[src/albm_if.sv]
interface albm_in_if #(
    parameter int SAMPLE_BITS = albm_pkg::SAMPLE_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [SAMPLE_BITS-1:0]         sample;
    logic [albm_pkg::TIME_W-1:0]    now_ms;

    modport source (output valid, output sample, output now_ms, input ready);
    modport sink (input valid, input sample, input now_ms, output ready);
endinterface

interface albm_out_if;
    logic                           valid;
    logic                           ready;
    logic [albm_pkg::BAR_W-1:0]     bar_height;
    logic [albm_pkg::BAR_W-1:0]     peak_pos;
    logic [albm_pkg::SMOOTH_W-1:0]  smoothed_level;

    modport source (output valid, output bar_height, output peak_pos,
                    output smoothed_level, input ready);
    modport sink (input valid, input bar_height, input peak_pos,
                  input smoothed_level, output ready);
endinterface

[src/albm_window.sv]
module albm_window #(
    parameter int WINDOW_LEN  = albm_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = albm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  albm_pkg::win_req_t       req,
    input  logic [SAMPLE_BITS-2:0]   wr_data,
    output albm_pkg::win_stat_t      stat,
    output logic [SAMPLE_BITS-2:0]   lo,
    output logic [SAMPLE_BITS-2:0]   hi
);
    import albm_pkg::*;

    localparam int GW     = SAMPLE_BITS - 1;
    localparam int PTR_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam logic [PTR_W-1:0]  LAST_IDX = PTR_W'(WINDOW_LEN - 1);
    localparam logic [FILL_W-1:0] FULL     = FILL_W'(WINDOW_LEN);

    logic [GW-1:0]     mem [WINDOW_LEN];
    logic [GW-1:0]     rd_data_reg;
    logic [GW-1:0]     lo_reg;
    logic [GW-1:0]     hi_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  rd_idx_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              scanning_reg;
    logic              rd_live_reg;
    logic              rd_last_reg;
    logic              rd_ok_reg;
    logic              first_reg;
    logic              busy_reg;
    logic [GW-1:0]     rd_val;

    // Entries at or past the fill count were never written and read as zero.
    assign rd_val = rd_ok_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[ptr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rd_live_reg)
        begin
            if (first_reg)
            begin
                lo_reg <= rd_val;
                hi_reg <= rd_val;
            end
            else
            begin
                if (rd_val < lo_reg)
                begin
                    lo_reg <= rd_val;
                end
                if (rd_val > hi_reg)
                begin
                    hi_reg <= rd_val;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            fill_reg     <= '0;
            rd_idx_reg   <= '0;
            scanning_reg <= 1'b0;
            rd_live_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
            rd_ok_reg    <= 1'b0;
            first_reg    <= 1'b0;
            busy_reg     <= 1'b0;
        end
        else
        begin
            if (req.wr)
            begin
                ptr_reg <= (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                if (fill_reg != FULL)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end

            rd_live_reg <= scanning_reg;
            rd_last_reg <= scanning_reg && (rd_idx_reg == LAST_IDX);
            rd_ok_reg   <= FILL_W'(rd_idx_reg) < fill_reg;

            if (req.scan)
            begin
                scanning_reg <= 1'b1;
                rd_idx_reg   <= '0;
                busy_reg     <= 1'b1;
            end
            else if (scanning_reg)
            begin
                if (rd_idx_reg == LAST_IDX)
                begin
                    scanning_reg <= 1'b0;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end

            if (req.scan)
            begin
                first_reg <= 1'b1;
            end
            else if (rd_live_reg)
            begin
                first_reg <= 1'b0;
            end

            if (rd_live_reg && rd_last_reg)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign lo        = lo_reg;
    assign hi        = hi_reg;

endmodule

[src/audio_level_bar_meter_top.sv]
// Sound level bar meter with a peak-hold dot. Each item carries one raw microphone
// sample and a millisecond timestamp and yields one result: the bar height, the
// peak dot position and the smoothed level. The block works on one item at a time;
// an item is done only once the scan of the level window through the single read
// port of its memory has finished, and the bar division runs alongside that scan.
// A finished result waits in an output register while the next item is accepted.
// The window needs no clearing pass after reset: a fill count makes unwritten
// entries read as zero. Registers are to be written through the plain write port
// only while the block is idle; the block itself does not enforce this.
module audio_level_bar_meter_top #(
    parameter int WINDOW_LEN  = albm_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = albm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [albm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [albm_pkg::CFG_DATA_W-1:0]  cfg_data,
    albm_in_if.sink                          sample_ch,
    albm_out_if.source                       result_ch
);
    import albm_pkg::*;

    localparam int GW    = SAMPLE_BITS - 1;
    localparam int LF_W  = GW;
    localparam int AW    = (SAMPLE_BITS > AVG_MIN_W) ? SAMPLE_BITS : AVG_MIN_W;
    localparam int CW    = AW + 1;
    localparam int NUM_W = AW + BAR_W;
    localparam int LS_W  = LF_W + FILT_SHIFT;
    localparam int AS_W  = AW + AVG_SHIFT;

    localparam logic signed [CW-1:0] MID_SCALE = CW'(1 << (SAMPLE_BITS - 1));
    localparam logic [GW-1:0]        GATED_MAX = '1;

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] S_FILT = 3'd1;
    localparam logic [STATE_W-1:0] S_PREP = 3'd2;
    localparam logic [STATE_W-1:0] S_CHK  = 3'd3;
    localparam logic [STATE_W-1:0] S_DIV  = 3'd4;
    localparam logic [STATE_W-1:0] S_PEAK = 3'd5;
    localparam logic [STATE_W-1:0] S_FALL = 3'd6;
    localparam logic [STATE_W-1:0] S_AVG  = 3'd7;

    logic [STATE_W-1:0]   state_reg;

    logic [DC_W-1:0]      dc_offset_reg;
    logic [NF_W-1:0]      noise_floor_reg;
    logic [BAR_W-1:0]     bar_top_reg;
    logic [TIMEOUT_W-1:0] peak_timeout_reg;
    logic [BAR_W-1:0]     peak_fall_reg;

    logic [LF_W-1:0]      level_reg;
    logic [AW-1:0]        min_avg_reg;
    logic [AW-1:0]        max_avg_reg;
    logic [BAR_W-1:0]     peak_hold_reg;
    logic [TIME_W-1:0]    peak_stamp_reg;
    logic [BAR_W-1:0]     fall_count_reg;
    logic [QCNT_W-1:0]    bit_cnt_reg;

    logic [GW-1:0]        g_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [NUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     dsh_reg;
    logic [AW-1:0]        div_reg;
    logic [BAR_W-1:0]     quo_reg;
    logic                 ovf_reg;

    logic                 out_valid_reg;
    logic [BAR_W-1:0]     bar_height_reg;
    logic [BAR_W-1:0]     peak_pos_reg;
    logic [SMOOTH_W-1:0]  smoothed_reg;

    logic                 in_accept;
    logic                 out_free;
    logic signed [CW-1:0] raw_s;
    logic signed [CW-1:0] dc_s;
    logic signed [CW-1:0] centred;
    logic [AW-1:0]        mag;
    logic [AW-1:0]        mag_gate;
    logic [GW-1:0]        g_in;
    logic [LS_W-1:0]      lf_sum;
    logic [LF_W-1:0]      level_next;
    logic [AW-1:0]        lf_ext;
    logic [AW-1:0]        dpos;
    logic [NUM_W-1:0]     num_prod;
    logic [AW-1:0]        div_calc;
    logic                 rem_ge;
    logic [BAR_W-1:0]     height;
    logic [BAR_W-1:0]     hold_new;
    logic                 new_peak;
    logic [TIME_W-1:0]    elapsed;
    logic                 timed_out;
    logic [BAR_W-1:0]     fc_inc;
    logic [AW-1:0]        span;
    logic [AW-1:0]        hi_adj;
    logic [AS_W-1:0]      min_sum;
    logic [AS_W-1:0]      max_sum;
    logic [AW-1:0]        min_next;
    logic [AW-1:0]        max_next;

    win_req_t             win_req;
    win_stat_t            win_stat;
    logic [GW-1:0]        win_lo;
    logic [GW-1:0]        win_hi;

    albm_window #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (win_req),
        .wr_data (g_reg),
        .stat    (win_stat),
        .lo      (win_lo),
        .hi      (win_hi)
    );

    assign sample_ch.ready = (state_reg == S_IDLE);
    assign in_accept       = sample_ch.valid && sample_ch.ready;
    assign out_free        = !out_valid_reg || result_ch.ready;

    // The sample is centered, rectified, gated and saturated to a window entry.
    always_comb
    begin
        raw_s    = $signed(CW'(sample_ch.sample));
        dc_s     = $signed({{(CW - DC_W){dc_offset_reg[DC_W-1]}}, dc_offset_reg});
        centred  = raw_s - MID_SCALE - dc_s;
        mag      = centred[CW-1] ? AW'(-centred) : AW'(centred);
        mag_gate = (mag > AW'(noise_floor_reg)) ? mag - AW'(noise_floor_reg) : '0;
        g_in     = (mag_gate > AW'(GATED_MAX)) ? GATED_MAX : GW'(mag_gate);
    end

    always_comb
    begin
        lf_sum     = {level_reg, {FILT_SHIFT{1'b0}}} - LS_W'(level_reg) + LS_W'(g_reg);
        level_next = lf_sum[LS_W-1:FILT_SHIFT];

        lf_ext   = AW'(level_reg);
        dpos     = (lf_ext > min_avg_reg) ? lf_ext - min_avg_reg : '0;
        num_prod = NUM_W'(bar_top_reg) * NUM_W'(dpos);
        div_calc = (max_avg_reg > min_avg_reg) ? max_avg_reg - min_avg_reg : AW'(1);

        rem_ge = rem_reg >= dsh_reg;

        if (ovf_reg || (quo_reg > bar_top_reg))
        begin
            height = bar_top_reg;
        end
        else
        begin
            height = quo_reg;
        end
        new_peak = height > peak_hold_reg;
        hold_new = new_peak ? height : peak_hold_reg;

        elapsed   = now_reg - peak_stamp_reg;
        timed_out = elapsed > TIME_W'(peak_timeout_reg);
        fc_inc    = fall_count_reg + 8'd1;

        span     = AW'(win_hi) - AW'(win_lo);
        hi_adj   = (span < AW'(bar_top_reg)) ? AW'(win_lo) + AW'(bar_top_reg) : AW'(win_hi);
        min_sum  = {min_avg_reg, {AVG_SHIFT{1'b0}}} - AS_W'(min_avg_reg) + AS_W'(win_lo);
        max_sum  = {max_avg_reg, {AVG_SHIFT{1'b0}}} - AS_W'(max_avg_reg) + AS_W'(hi_adj);
        min_next = min_sum[AS_W-1:AVG_SHIFT];
        max_next = max_sum[AS_W-1:AVG_SHIFT];
    end

    assign win_req.wr   = (state_reg == S_FILT);
    assign win_req.scan = (state_reg == S_FILT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_offset_reg    <= DC_OFFSET_RESET;
            noise_floor_reg  <= NOISE_FLOOR_RESET;
            bar_top_reg      <= BAR_TOP_RESET;
            peak_timeout_reg <= PEAK_TIMEOUT_RESET;
            peak_fall_reg    <= PEAK_FALL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DC_OFFSET:        dc_offset_reg    <= cfg_data[DC_W-1:0];
                CFG_NOISE_FLOOR:      noise_floor_reg  <= cfg_data[NF_W-1:0];
                CFG_BAR_TOP:          bar_top_reg      <= cfg_data[BAR_W-1:0];
                CFG_PEAK_TIMEOUT_MS:  peak_timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                CFG_PEAK_FALL_FRAMES: peak_fall_reg    <= cfg_data[BAR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            level_reg      <= LF_W'(LEVEL_RESET);
            min_avg_reg    <= '0;
            max_avg_reg    <= AW'(MAX_AVG_RESET);
            peak_hold_reg  <= '0;
            peak_stamp_reg <= '0;
            fall_count_reg <= '0;
            bit_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_PEAK) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= S_FILT;
                    end
                end
                S_FILT:
                begin
                    level_reg <= level_next;
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    bit_cnt_reg <= QCNT_W'(BAR_W - 1);
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg <= S_PEAK;
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    end
                end
                S_PEAK:
                begin
                    if (out_free)
                    begin
                        peak_hold_reg <= hold_new;
                        if (new_peak)
                        begin
                            peak_stamp_reg <= now_reg;
                        end
                        state_reg <= S_FALL;
                    end
                end
                S_FALL:
                begin
                    if (timed_out)
                    begin
                        if (fc_inc >= peak_fall_reg)
                        begin
                            fall_count_reg <= '0;
                            if (peak_hold_reg != '0)
                            begin
                                peak_hold_reg <= peak_hold_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            fall_count_reg <= fc_inc;
                        end
                    end
                    state_reg <= S_AVG;
                end
                S_AVG:
                begin
                    if (!win_stat.busy)
                    begin
                        min_avg_reg <= min_next;
                        max_avg_reg <= max_next;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            g_reg   <= g_in;
            now_reg <= sample_ch.now_ms;
        end
        if (state_reg == S_PREP)
        begin
            rem_reg <= num_prod;
            div_reg <= div_calc;
        end
        if (state_reg == S_CHK)
        begin
            ovf_reg <= rem_reg >= {div_reg, {BAR_W{1'b0}}};
            dsh_reg <= {1'b0, div_reg, {(BAR_W - 1){1'b0}}};
        end
        if (state_reg == S_DIV)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[BAR_W-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if ((state_reg == S_PEAK) && out_free)
        begin
            bar_height_reg <= height;
            peak_pos_reg   <= hold_new;
            smoothed_reg   <= SMOOTH_W'(level_reg);
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.bar_height     = bar_height_reg;
    assign result_ch.peak_pos       = peak_pos_reg;
    assign result_ch.smoothed_level = smoothed_reg;

    a_idle_window_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !win_stat.busy)
        else $error("window scan still running while idle");

    a_accept_starts_filter: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_FILT))
        else $error("accepted item did not start processing");

    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> ((state_reg == S_DIV) || (state_reg == S_PEAK)))
        else $error("division left to an unexpected state");

    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILT) |=> win_stat.busy)
        else $error("window scan did not start after the filter step");

endmodule

[tb/sv/audio_level_bar_meter_checker.sv]
module audio_level_bar_meter_checker #(
    parameter int WINDOW_LEN  = albm_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = albm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [albm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [albm_pkg::CFG_DATA_W-1:0]  cfg_data,
    albm_in_if                               sample_ch,
    albm_out_if                              result_ch,
    output int                               fail_count,
    output int                               pending
);
    import albm_pkg::*;

    localparam longint MID_SCALE = longint'(1) << (SAMPLE_BITS - 1);
    localparam longint GATED_MAX = MID_SCALE - 1;

    typedef struct packed {
        logic [BAR_W-1:0]    bar_height;
        logic [BAR_W-1:0]    peak_pos;
        logic [SMOOTH_W-1:0] smoothed_level;
    } meter_result_t;

    logic signed [DC_W-1:0] dc_offset_q;
    logic [NF_W-1:0]        noise_floor_q;
    logic [BAR_W-1:0]       bar_top_q;
    logic [TIMEOUT_W-1:0]   timeout_q;
    logic [BAR_W-1:0]       fall_frames_q;

    int unsigned            level_filt;
    int unsigned            min_avg;
    int unsigned            max_avg;
    logic [BAR_W-1:0]       peak_hold;
    logic [TIME_W-1:0]      peak_stamp;
    logic [BAR_W-1:0]       fall_count;
    logic [NF_W-1:0]        level_window [WINDOW_LEN];
    int                     window_ptr;

    meter_result_t          expected_frames [$];

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_DC_OFFSET:        dc_offset_q   = value[DC_W-1:0];
            CFG_NOISE_FLOOR:      noise_floor_q = value[NF_W-1:0];
            CFG_BAR_TOP:          bar_top_q     = value[BAR_W-1:0];
            CFG_PEAK_TIMEOUT_MS:  timeout_q     = value[TIMEOUT_W-1:0];
            CFG_PEAK_FALL_FRAMES: fall_frames_q = value[BAR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic advance_meter(input logic [SAMPLE_BITS-1:0] smp,
                                 input logic [TIME_W-1:0] stamp,
                                 output meter_result_t frame);
        longint            centred;
        longint            mag;
        longint            gated;
        longint            divisor;
        longint            height;
        int unsigned       lo;
        int unsigned       hi;
        logic [TIME_W-1:0] elapsed;

        centred = longint'(smp) - MID_SCALE - longint'(dc_offset_q);
        mag = (centred < 0) ? -centred : centred;
        gated = (mag <= longint'(noise_floor_q)) ? 0 : mag - longint'(noise_floor_q);
        if (gated > GATED_MAX)
        begin
            gated = GATED_MAX;
        end
        level_filt = (level_filt * 7 + 32'(gated)) >> FILT_SHIFT;

        divisor = longint'(max_avg) - longint'(min_avg);
        if (divisor < 1)
        begin
            divisor = 1;
        end
        height = (longint'(bar_top_q) * (longint'(level_filt) - longint'(min_avg))) / divisor;
        if (height < 0)
        begin
            height = 0;
        end
        else if (height > longint'(bar_top_q))
        begin
            height = longint'(bar_top_q);
        end

        if (height > longint'(peak_hold))
        begin
            peak_hold = BAR_W'(height);
            peak_stamp = stamp;
        end

        frame.bar_height = BAR_W'(height);
        frame.peak_pos = peak_hold;
        frame.smoothed_level = SMOOTH_W'(level_filt);

        elapsed = stamp - peak_stamp;
        if (elapsed > TIME_W'(timeout_q))
        begin
            fall_count = fall_count + 8'd1;
            if (fall_count >= fall_frames_q)
            begin
                if (peak_hold > 0)
                begin
                    peak_hold = peak_hold - 8'd1;
                end
                fall_count = '0;
            end
        end

        level_window[window_ptr] = NF_W'(gated);
        window_ptr = (window_ptr + 1 >= WINDOW_LEN) ? 0 : window_ptr + 1;

        lo = 32'(level_window[0]);
        hi = 32'(level_window[0]);
        for (int i = 1; i < WINDOW_LEN; i++)
        begin
            if (32'(level_window[i]) < lo)
            begin
                lo = 32'(level_window[i]);
            end
            else if (32'(level_window[i]) > hi)
            begin
                hi = 32'(level_window[i]);
            end
        end
        if (hi - lo < 32'(bar_top_q))
        begin
            hi = lo + 32'(bar_top_q);
        end
        min_avg = (min_avg * 63 + lo) >> AVG_SHIFT;
        max_avg = (max_avg * 63 + hi) >> AVG_SHIFT;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        meter_result_t got;
        meter_result_t want;
        meter_result_t frame;

        if (!rst_n)
        begin
            fail_count = 0;
            dc_offset_q = DC_OFFSET_RESET;
            noise_floor_q = NOISE_FLOOR_RESET;
            bar_top_q = BAR_TOP_RESET;
            timeout_q = PEAK_TIMEOUT_RESET;
            fall_frames_q = PEAK_FALL_RESET;
            level_filt = LEVEL_RESET;
            min_avg = 0;
            max_avg = MAX_AVG_RESET;
            peak_hold = '0;
            peak_stamp = '0;
            fall_count = '0;
            foreach (level_window[i])
            begin
                level_window[i] = '0;
            end
            window_ptr = 0;
            expected_frames.delete();
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.bar_height = result_ch.bar_height;
                got.peak_pos = result_ch.peak_pos;
                got.smoothed_level = result_ch.smoothed_level;
                if (expected_frames.size() == 0)
                begin
                    report_mismatch("result item with no input item outstanding");
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (got.bar_height !== want.bar_height)
                    begin
                        report_mismatch($sformatf("bar_height got %0d expected %0d",
                                                  got.bar_height, want.bar_height));
                    end
                    if (got.peak_pos !== want.peak_pos)
                    begin
                        report_mismatch($sformatf("peak_pos got %0d expected %0d",
                                                  got.peak_pos, want.peak_pos));
                    end
                    if (got.smoothed_level !== want.smoothed_level)
                    begin
                        report_mismatch($sformatf("smoothed_level got %0d expected %0d",
                                                  got.smoothed_level, want.smoothed_level));
                    end
                end
            end
            if (cfg_wr_en)
            begin
                write_register(cfg_index, cfg_data);
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                advance_meter(sample_ch.sample, sample_ch.now_ms, frame);
                expected_frames.push_back(frame);
            end
        end
        pending = expected_frames.size();
    end

endmodule

[tb/sv/tb_audio_level_bar_meter_top.sv]
module tb_audio_level_bar_meter_top;
    import albm_pkg::*;

    localparam int LATENCY     = WINDOW_LEN_DEF + 4;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int                     fail_count;
    int                     pending;
    int                     cycle_count = 0;
    int                     sender_idle_pct = 0;
    int                     stall_pct = 0;
    int                     ready_hold = 0;
    int                     dc_now = 0;
    int                     amp_now = 100;
    logic [TIME_W-1:0]      time_ms = '0;

    albm_in_if  sample_ch ();
    albm_out_if result_ch ();

    audio_level_bar_meter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    audio_level_bar_meter_checker meter_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_ch  (sample_ch),
        .result_ch  (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver counts out any long hold-off itself, then stalls at random.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
            begin
                result_ch.ready = 1'b0;
                ready_hold--;
            end
            else
            begin
                result_ch.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_item(input logic [SAMPLE_BITS_DEF-1:0] smp,
                             input logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid = 1'b1;
        sample_ch.sample = smp;
        sample_ch.now_ms = stamp;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic settle_block();
        sample_ch.valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_DATA_W'(value);
        @(negedge clk);
    endtask

    task automatic set_meter_config(input int dc, input int floor_level, input int top,
                                    input int timeout_ms, input int fall_frames);
        write_register(CFG_DC_OFFSET, dc & 12'hFFF);
        write_register(CFG_NOISE_FLOOR, floor_level);
        write_register(CFG_BAR_TOP, top);
        write_register(CFG_PEAK_TIMEOUT_MS, timeout_ms);
        write_register(CFG_PEAK_FALL_FRAMES, fall_frames);
        cfg_wr_en = 1'b0;
        dc_now = dc;
    endtask

    function automatic int pick_setting(input int lo, input int hi,
                                        input int typ_lo, input int typ_hi);
        int roll;

        roll = $urandom_range(9);
        if (roll == 0)
        begin
            return lo;
        end
        if (roll == 1)
        begin
            return hi;
        end
        return typ_lo + int'($urandom_range(typ_hi - typ_lo));
    endfunction

    task automatic next_time();
        int roll;

        roll = $urandom_range(99);
        if (roll < 85)
        begin
            time_ms = time_ms + $urandom_range(40);
        end
        else if (roll < 95)
        begin
            time_ms = time_ms + $urandom_range(3000, 41);
        end
        else if (roll < 98)
        begin
            time_ms = time_ms + $urandom_range(80000, 3001);
        end
        else
        begin
            time_ms = $urandom();
        end
    endtask

    task automatic run_sound(input int count, input bit quiet);
        int                         level;
        logic [SAMPLE_BITS_DEF-1:0] smp;

        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) == 0)
            begin
                case ($urandom_range(2))
                    0: amp_now = 0;
                    1: amp_now = $urandom_range(60);
                    default: amp_now = $urandom_range(2047);
                endcase
            end
            if (quiet)
            begin
                smp = SAMPLE_BITS_DEF'(2048 - 500 + int'($urandom_range(1000)));
            end
            else if ($urandom_range(19) == 0)
            begin
                smp = SAMPLE_BITS_DEF'($urandom_range(4095));
            end
            else
            begin
                level = 2048 + dc_now + int'($urandom_range(2 * amp_now)) - amp_now;
                if (level < 0)
                begin
                    level = 0;
                end
                else if (level > 4095)
                begin
                    level = 4095;
                end
                smp = SAMPLE_BITS_DEF'(level);
            end
            next_time();
            send_item(smp, time_ms);
        end
        sample_ch.valid = 1'b0;
    endtask

    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        sample_ch.now_ms = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(12'd0, 32'd0);
        send_item(12'd4095, 32'hFFFF_FFFF);
        send_item(12'd2048, 32'd1);
        send_item(12'd2078, 32'd2);
        send_item(12'd2079, 32'd3);
        send_item(12'd2018, 32'd4);
        settle_block();
        set_meter_config(2047, 0, 255, 0, 1);
        send_item(12'd0, 32'd10);
        send_item(12'd4095, 32'd11);
        send_item(12'd2048, 32'd12);
        send_item(12'd2048, 32'd13);
        settle_block();
        set_meter_config(-2048, 2047, 0, 65535, 0);
        send_item(12'd4095, 32'd100);
        send_item(12'd0, 32'd200);
        send_item(12'd2000, 32'd70000);
        send_item(12'd2048, 32'd70001);
        settle_block();
        set_meter_config(-1, 1, 1, 0, 255);
        send_item(12'd4095, 32'hFFFF_FFF0);
        send_item(12'd0, 32'hFFFF_FFF8);
        send_item(12'd2047, 32'h0000_0004);
        send_item(12'd2049, 32'h0000_0010);
        send_item(12'd1234, 32'hAAAA_5555);
        send_item(12'd2900, 32'h5555_AAAA);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 51;
                    stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 51;
                end
                default:
                begin
                    sender_idle_pct = 33;
                    stall_pct = 33;
                end
            endcase
            time_ms = 32'hFFFF_FFFF - $urandom_range(5000);
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                settle_block();
                set_meter_config(pick_setting(-2048, 2047, -150, 150),
                                 pick_setting(0, 2047, 0, 120),
                                 pick_setting(1, 255, 8, 200),
                                 pick_setting(0, 65535, 0, 2500),
                                 pick_setting(0, 255, 1, 12));
                if (phase == 0 && chunk == 0)
                begin
                    ready_hold = 400;
                end
                run_sound(95, 1'b0);
            end
            if (phase == 0)
            begin
                // Long silence with a zero bar lets both averages meet.
                settle_block();
                set_meter_config(0, 2047, 0, 0, 0);
                run_sound(300, 1'b1);
            end
        end

        settle_block();
        if (fail_count == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
src/albm_pkg.sv
src/albm_if.sv
src/albm_window.sv
src/audio_level_bar_meter_top.sv
tb/sv/audio_level_bar_meter_checker.sv
tb/sv/tb_audio_level_bar_meter_top.sv
